FILE: hdl/sha1md_pkg.sv
// Shared types and constants of the SHA-1 message digest block.
package sha1md_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_ADD,
        ST_PAD_ONE,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        BSEL_DATA,
        BSEL_ONE,
        BSEL_ZERO,
        BSEL_LEN
    } t_bsel;

    typedef struct packed {
        logic       absorb;
        t_bsel      bsel;
        logic       snap_len;
        logic       round;
        logic [1:0] phase;
        logic       add;
        logic       restart;
        logic [2:0] widx;
    } t_cmd;

    typedef struct packed {
        logic [5:0] pos;
    } t_sts;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [4:0][31:0] H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] POS_FULL   = 6'd63;
    localparam logic [5:0] POS_PRELEN = 6'd55;
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [6:0] ROUND_P1   = 7'd20;
    localparam logic [6:0] ROUND_P2   = 7'd40;
    localparam logic [6:0] ROUND_P3   = 7'd60;
    localparam logic [2:0] WIDX_LAST  = 3'd4;

endpackage

FILE: hdl/sha1md_dp.sv
// Datapath: block shift line, byte counter, round unit and chaining words.
module sha1md_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_data,
    input  sha1md_pkg::t_cmd     i_cmd,
    output sha1md_pkg::t_sts     o_sts,
    output logic [31:0]          o_word
);

    logic [511:0]     r_blk;
    logic [63:0]      r_cnt;
    logic [63:0]      r_len;
    logic [4:0][31:0] r_h;
    logic [31:0]      r_a, r_b, r_c, r_d, r_e;

    logic [7:0]       n_byte;
    logic [63:0]      n_cnt;
    logic [31:0]      n_w;
    logic [31:0]      n_f;
    logic [31:0]      n_k;
    logic [31:0]      n_sum;
    logic [31:0]      n_x;

    always_comb begin
        case (i_cmd.bsel)
            sha1md_pkg::BSEL_DATA: n_byte = i_data;
            sha1md_pkg::BSEL_ONE:  n_byte = sha1md_pkg::PAD_MARK;
            sha1md_pkg::BSEL_ZERO: n_byte = 8'h00;
            sha1md_pkg::BSEL_LEN:  n_byte = r_len[63:56];
            default:               n_byte = 8'h00;
        endcase
    end

    assign n_cnt = r_cnt + {63'd0, i_cmd.absorb};

    assign n_x = r_blk[95:64] ^ r_blk[255:224] ^ r_blk[447:416] ^ r_blk[511:480];
    assign n_w = {n_x[30:0], n_x[31]};

    always_comb begin
        case (i_cmd.phase)
            2'd0: begin
                n_f = r_d ^ (r_b & (r_c ^ r_d));
                n_k = sha1md_pkg::K0;
            end
            2'd1: begin
                n_f = r_b ^ r_c ^ r_d;
                n_k = sha1md_pkg::K1;
            end
            2'd2: begin
                n_f = (r_b & r_c) | (r_d & (r_b | r_c));
                n_k = sha1md_pkg::K2;
            end
            default: begin
                n_f = r_b ^ r_c ^ r_d;
                n_k = sha1md_pkg::K3;
            end
        endcase
    end

    assign n_sum = {r_a[26:0], r_a[31:27]} + r_e + r_blk[511:480] + n_f + n_k;

    always_ff @(posedge i_clk) begin
        if (i_cmd.absorb) begin
            r_blk <= {r_blk[503:0], n_byte};
        end else if (i_cmd.round) begin
            r_blk <= {r_blk[479:0], n_w};
        end
        if (i_cmd.snap_len) begin
            r_len <= {n_cnt[60:0], 3'b000};
        end else if (i_cmd.absorb && i_cmd.bsel == sha1md_pkg::BSEL_LEN) begin
            r_len <= {r_len[55:0], 8'h00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_h   <= sha1md_pkg::H_INIT;
            r_a   <= sha1md_pkg::H_INIT[0];
            r_b   <= sha1md_pkg::H_INIT[1];
            r_c   <= sha1md_pkg::H_INIT[2];
            r_d   <= sha1md_pkg::H_INIT[3];
            r_e   <= sha1md_pkg::H_INIT[4];
        end else if (i_cmd.restart) begin
            r_cnt <= '0;
            r_h   <= sha1md_pkg::H_INIT;
            r_a   <= sha1md_pkg::H_INIT[0];
            r_b   <= sha1md_pkg::H_INIT[1];
            r_c   <= sha1md_pkg::H_INIT[2];
            r_d   <= sha1md_pkg::H_INIT[3];
            r_e   <= sha1md_pkg::H_INIT[4];
        end else begin
            r_cnt <= n_cnt;
            if (i_cmd.round) begin
                r_a <= n_sum;
                r_b <= r_a;
                r_c <= {r_b[1:0], r_b[31:2]};
                r_d <= r_c;
                r_e <= r_d;
            end else if (i_cmd.add) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
                r_a    <= r_h[0] + r_a;
                r_b    <= r_h[1] + r_b;
                r_c    <= r_h[2] + r_c;
                r_d    <= r_h[3] + r_d;
                r_e    <= r_h[4] + r_e;
            end
        end
    end

    always_comb begin
        case (i_cmd.widx)
            3'd0:    o_word = r_h[0];
            3'd1:    o_word = r_h[1];
            3'd2:    o_word = r_h[2];
            3'd3:    o_word = r_h[3];
            3'd4:    o_word = r_h[4];
            default: o_word = '0;
        endcase
    end

    assign o_sts.pos = r_cnt[5:0];

endmodule

FILE: hdl/sha1md_ctrl.sv
// Controller: sequences absorption, padding, compression rounds and digest output.
module sha1md_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tuser,
    input  logic             i_s_tlast,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    input  sha1md_pkg::t_sts i_sts,
    output sha1md_pkg::t_cmd o_cmd
);

    sha1md_pkg::t_state r_state, n_state;
    sha1md_pkg::t_state r_ret, n_ret;
    logic [6:0]         r_round, n_round;
    logic [2:0]         r_widx, n_widx;

    logic               w_full;

    assign w_full = (i_sts.pos == sha1md_pkg::POS_FULL);

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_round = r_round;
        n_widx  = r_widx;
        unique case (r_state)
            sha1md_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_s_tuser && w_full) begin
                        n_state = sha1md_pkg::ST_COMP;
                        n_round = '0;
                        n_ret   = i_s_tlast ? sha1md_pkg::ST_PAD_ONE : sha1md_pkg::ST_IDLE;
                    end else if (i_s_tlast) begin
                        n_state = sha1md_pkg::ST_PAD_ONE;
                    end
                end
            end
            sha1md_pkg::ST_COMP: begin
                n_round = r_round + 7'd1;
                if (r_round == sha1md_pkg::ROUND_LAST) begin
                    n_state = sha1md_pkg::ST_ADD;
                end
            end
            sha1md_pkg::ST_ADD: begin
                n_state = r_ret;
                n_widx  = '0;
            end
            sha1md_pkg::ST_PAD_ONE: begin
                if (w_full) begin
                    n_state = sha1md_pkg::ST_COMP;
                    n_round = '0;
                    n_ret   = sha1md_pkg::ST_PAD_ZERO;
                end else if (i_sts.pos == sha1md_pkg::POS_PRELEN) begin
                    n_state = sha1md_pkg::ST_PAD_LEN;
                end else begin
                    n_state = sha1md_pkg::ST_PAD_ZERO;
                end
            end
            sha1md_pkg::ST_PAD_ZERO: begin
                if (w_full) begin
                    n_state = sha1md_pkg::ST_COMP;
                    n_round = '0;
                    n_ret   = sha1md_pkg::ST_PAD_ZERO;
                end else if (i_sts.pos == sha1md_pkg::POS_PRELEN) begin
                    n_state = sha1md_pkg::ST_PAD_LEN;
                end
            end
            sha1md_pkg::ST_PAD_LEN: begin
                if (w_full) begin
                    n_state = sha1md_pkg::ST_COMP;
                    n_round = '0;
                    n_ret   = sha1md_pkg::ST_OUT;
                end
            end
            sha1md_pkg::ST_OUT: begin
                if (i_m_tready) begin
                    n_widx = r_widx + 3'd1;
                    if (r_widx == sha1md_pkg::WIDX_LAST) begin
                        n_state = sha1md_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = sha1md_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.bsel     = sha1md_pkg::BSEL_DATA;
        o_cmd.widx     = r_widx;
        o_s_tready     = 1'b0;
        o_m_tvalid     = 1'b0;
        if (r_round < sha1md_pkg::ROUND_P1) begin
            o_cmd.phase = 2'd0;
        end else if (r_round < sha1md_pkg::ROUND_P2) begin
            o_cmd.phase = 2'd1;
        end else if (r_round < sha1md_pkg::ROUND_P3) begin
            o_cmd.phase = 2'd2;
        end else begin
            o_cmd.phase = 2'd3;
        end
        unique case (r_state)
            sha1md_pkg::ST_IDLE: begin
                o_s_tready     = 1'b1;
                o_cmd.absorb   = i_s_tvalid && i_s_tuser;
                o_cmd.snap_len = i_s_tvalid && i_s_tlast;
            end
            sha1md_pkg::ST_COMP: begin
                o_cmd.round = 1'b1;
            end
            sha1md_pkg::ST_ADD: begin
                o_cmd.add = 1'b1;
            end
            sha1md_pkg::ST_PAD_ONE: begin
                o_cmd.absorb = 1'b1;
                o_cmd.bsel   = sha1md_pkg::BSEL_ONE;
            end
            sha1md_pkg::ST_PAD_ZERO: begin
                o_cmd.absorb = 1'b1;
                o_cmd.bsel   = sha1md_pkg::BSEL_ZERO;
            end
            sha1md_pkg::ST_PAD_LEN: begin
                o_cmd.absorb = 1'b1;
                o_cmd.bsel   = sha1md_pkg::BSEL_LEN;
            end
            sha1md_pkg::ST_OUT: begin
                o_m_tvalid    = 1'b1;
                o_cmd.restart = i_m_tready && (r_widx == sha1md_pkg::WIDX_LAST);
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha1md_pkg::ST_IDLE;
            r_ret   <= sha1md_pkg::ST_IDLE;
            r_round <= '0;
            r_widx  <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_round <= n_round;
            r_widx  <= n_widx;
        end
    end

endmodule

FILE: hdl/sha1_message_digest_top.sv
// Top level of the SHA-1 message digest block: controller plus datapath.
//
// Channel   Dir  tdata (low bit up)                     tuser     tlast
// s_axis    in   data_byte[7:0]                         has_byte  last
// m_axis    out  digest_word[31:0], word_index[34:32]   -         final_word
//
// Each byte item is absorbed into the block shift line; the 64th byte of a block
// starts 80 compression rounds followed by the chaining add.
// A last item pads one byte per cycle, pausing while a full block is compressed
// (9 to 72 bytes, with one or two compressions), then shows the five digest
// words, one per output request. Input ready is high only while idle. An output
// stall holds the current word. Reset is synchronous and restores the initial
// chaining words and a zero byte count.
module sha1_message_digest_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // data_byte[7:0]
    input  logic        i_s_tuser,   // has_byte
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // digest_word[31:0], word_index[34:32], zero fill
    output logic        o_m_tlast
);

    sha1md_pkg::t_cmd w_cmd;
    sha1md_pkg::t_sts w_sts;
    logic [31:0]      w_word;

    sha1md_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sha1md_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_s_tdata),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_word  (w_word)
    );

    assign o_m_tdata = {5'd0, w_cmd.widx, w_word};
    assign o_m_tlast = (w_cmd.widx == sha1md_pkg::WIDX_LAST);

endmodule

FILE: hdl/sha1md_chk.sv
// Port-level checker of the SHA-1 message digest block and its bind.
module sha1md_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic        i_s_tuser,
    input logic        i_s_tlast,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata,
    input logic        o_m_tlast
);

    // Input requests and digest words never overlap.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while digest output is valid");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled digest word changed");

    a_tlast_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (o_m_tdata[34:32] == sha1md_pkg::WIDX_LAST)))
        else $error("tlast does not match the fifth word");

    // A request without tlast produces no digest word right after it.
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !i_s_tlast) |=> !o_m_tvalid)
        else $error("digest output after a non-last request");

    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> (o_s_tready && !o_m_tvalid))
        else $error("block not idle after the final digest word");

endmodule

bind sha1_message_digest_top sha1md_chk u_chk (.*);
